>>> sv/lsch_pkg.sv
// Package for the lottery scheduler: operation codes and fixed field widths.
// No dependencies; used by lsch_mod_unit and lottery_scheduler_core.
`default_nettype none

package lsch_pkg;

    // Fixed widths of the word fields
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 16;
    localparam int RAND_W  = 16;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_STATUS = 2'd1,
        MODE_DRAW   = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

endpackage

`default_nettype wire

>>> sv/lottery_scheduler_core.sv
// Lottery scheduler core: sequencer around the slot table RAM and the remainder unit.
// Depends on lsch_pkg, lsch_table and lsch_mod_unit.
//
// Usage
//   Input channel (in_valid / in_stall) carries one command word: mode, slot,
//   dest_slot, ticket_value, is_ready, random_word. Output channel
//   (out_valid / out_stall) returns exactly one result word per command.
//   Commands run one at a time; in_stall is high while a command is in work.
// Steps per command, from accept to result
//   set tickets / status change : read, write back, result
//   transfer                    : read src, write src, read dst, write dst,
//                                 result
//   draw                        : two walks over the table RAM (one read
//                                 port, one entry a cycle) around a 16-step
//                                 remainder.
//   Slot numbers outside the table skip the table access and go straight to the result.
// Reset clears the sequencer and the table valid flags at once, so all
// slots read as zero tickets, not ready; no clearing sweep is needed.
// A stalled result holds in the output register; the core takes the next
// command meanwhile and only waits when it has a second result to deliver.
`default_nettype none

module lottery_scheduler_core #(
    parameter int SLOT_COUNT  = 16,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   mode,
    input  wire logic [lsch_pkg::SLOT_W-1:0]  slot,
    input  wire logic [lsch_pkg::SLOT_W-1:0]  dest_slot,
    input  wire logic [lsch_pkg::VALUE_W-1:0] ticket_value,
    input  wire logic                         is_ready,
    input  wire logic [lsch_pkg::RAND_W-1:0]  random_word,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [lsch_pkg::SLOT_W-1:0]       winner_slot,
    output logic                              winner_valid,
    output logic [lsch_pkg::RAND_W-1:0]       lucky_ticket,
    output logic [lsch_pkg::VALUE_W-1:0]      moved_tickets
);

    localparam int AW    = $clog2(SLOT_COUNT);
    localparam int SUM_W = TICKET_BITS + AW;
    localparam int CW    = (SUM_W > lsch_pkg::RAND_W) ? SUM_W : lsch_pkg::RAND_W;
    localparam int VW    = (TICKET_BITS > lsch_pkg::VALUE_W) ? TICKET_BITS : lsch_pkg::VALUE_W;
    localparam logic [VW-1:0]  TMAX_EXT = VW'({TICKET_BITS{1'b1}});
    localparam logic [AW:0]    SLOTS    = (AW + 1)'(SLOT_COUNT);
    localparam logic [8:0]     SLOTS9   = 9'(SLOT_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_XF_SRC,
        ST_XF_DRD,
        ST_XF_DST,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                  state_reg,   state_next;
    lsch_pkg::mode_t         mode_reg,    mode_next;
    logic [AW-1:0]           src_reg,     src_next;
    logic [AW-1:0]           dst_reg,     dst_next;
    logic [lsch_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                    rdy_reg,     rdy_next;
    logic [lsch_pkg::RAND_W-1:0]  rnd_reg,   rnd_next;
    logic [TICKET_BITS-1:0]  moved_reg,   moved_next;
    logic [CW-1:0]           total_reg,   total_next;
    logic [CW-1:0]           low_reg,     low_next;
    logic [lsch_pkg::RAND_W-1:0]  drawn_reg, drawn_next;
    logic [AW:0]             issue_reg,   issue_next;
    logic                    pend_reg,    pend_next;
    logic [AW-1:0]           pend_idx_reg, pend_idx_next;
    logic [AW-1:0]           win_idx_reg, win_idx_next;
    logic                    found_reg,   found_next;
    logic                    out_vld_reg, out_vld_next;
    logic [lsch_pkg::SLOT_W-1:0]  o_slot_reg,  o_slot_next;
    logic                    o_win_reg,   o_win_next;
    logic [lsch_pkg::RAND_W-1:0]  o_drawn_reg, o_drawn_next;
    logic [lsch_pkg::VALUE_W-1:0] o_moved_reg, o_moved_next;

    // table port
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    rd_ready;
    logic [TICKET_BITS-1:0]  rd_count;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic                    wr_ready;
    logic [TICKET_BITS-1:0]  wr_count;

    // remainder unit
    logic                    div_start;
    logic                    div_done;
    logic [lsch_pkg::RAND_W-1:0] div_rem;

    // datapath helpers
    logic                    accept;
    logic [8:0]              slot9;
    logic [8:0]              dest9;
    logic [8:0]              idx9;
    logic [VW-1:0]           val_ext;
    logic [VW-1:0]           have_ext;
    logic [VW-1:0]           moved_ext;
    logic [TICKET_BITS-1:0]  set_count;
    logic [TICKET_BITS-1:0]  take;
    logic [TICKET_BITS:0]    dst_sum;
    logic [CW-1:0]           hi_bound;
    logic                    issue_more;

    lsch_table #(
        .SLOT_COUNT  (SLOT_COUNT),
        .TICKET_BITS (TICKET_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_ready (rd_ready),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_ready (wr_ready),
        .wr_count (wr_count)
    );

    lsch_mod_unit #(
        .DIVISOR_W (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign slot9  = 9'(slot);
    assign dest9  = 9'(dest_slot);

    always_comb
    begin
        // saturate a set value to the count width
        val_ext   = VW'(value_reg);
        set_count = (val_ext > TMAX_EXT) ? {TICKET_BITS{1'b1}} : val_ext[TICKET_BITS-1:0];
        // transfer amount clamped to the source count
        have_ext  = VW'(rd_count);
        take      = (have_ext < val_ext) ? rd_count : val_ext[TICKET_BITS-1:0];
        dst_sum   = {1'b0, rd_count} + {1'b0, moved_reg};
        hi_bound  = low_reg + CW'(rd_count);
        issue_more = issue_reg < SLOTS;
        moved_ext = VW'(moved_reg);
        idx9      = 9'(win_idx_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        value_next    = value_reg;
        rdy_next      = rdy_reg;
        rnd_next      = rnd_reg;
        moved_next    = moved_reg;
        total_next    = total_reg;
        low_next      = low_reg;
        drawn_next    = drawn_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        win_idx_next  = win_idx_reg;
        found_next    = found_reg;
        out_vld_next  = out_vld_reg && out_stall;
        o_slot_next   = o_slot_reg;
        o_win_next    = o_win_reg;
        o_drawn_next  = o_drawn_reg;
        o_moved_next  = o_moved_reg;

        rd_en     = 1'b0;
        rd_addr   = src_reg;
        wr_en     = 1'b0;
        wr_addr   = src_reg;
        wr_ready  = rd_ready;
        wr_count  = rd_count;
        div_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = lsch_pkg::mode_t'(mode);
                    src_next     = slot9[AW-1:0];
                    dst_next     = dest9[AW-1:0];
                    value_next   = ticket_value;
                    rdy_next     = is_ready;
                    rnd_next     = random_word;
                    moved_next   = '0;
                    total_next   = '0;
                    low_next     = '0;
                    drawn_next   = '0;
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    win_idx_next = '0;
                    found_next   = 1'b0;
                    rd_addr      = slot9[AW-1:0];
                    unique case (lsch_pkg::mode_t'(mode))
                        lsch_pkg::MODE_SET, lsch_pkg::MODE_STATUS:
                        begin
                            rd_en      = slot9 < SLOTS9;
                            state_next = (slot9 < SLOTS9) ? ST_UPD : ST_DONE;
                        end
                        lsch_pkg::MODE_XFER:
                        begin
                            rd_en      = (slot9 < SLOTS9) && (dest9 < SLOTS9);
                            state_next = ((slot9 < SLOTS9) && (dest9 < SLOTS9)) ?
                                         ST_XF_SRC : ST_DONE;
                        end
                        lsch_pkg::MODE_DRAW:
                        begin
                            state_next = ST_SUM;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // set tickets / status change: write back the modified entry
            ST_UPD:
            begin
                wr_en   = 1'b1;
                wr_addr = src_reg;
                if (mode_reg == lsch_pkg::MODE_SET)
                begin
                    wr_count = set_count;
                end
                else
                begin
                    wr_ready = rdy_reg;
                end
                state_next = ST_DONE;
            end

            ST_XF_SRC:
            begin
                wr_en      = 1'b1;
                wr_addr    = src_reg;
                wr_count   = rd_count - take;
                moved_next = take;
                state_next = ST_XF_DRD;
            end

            // destination read after the source write, so src == dst sees the update
            ST_XF_DRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = dst_reg;
                state_next = ST_XF_DST;
            end

            ST_XF_DST:
            begin
                wr_en      = 1'b1;
                wr_addr    = dst_reg;
                wr_count   = dst_sum[TICKET_BITS] ? {TICKET_BITS{1'b1}} :
                             dst_sum[TICKET_BITS-1:0];
                state_next = ST_DONE;
            end

            // first walk: total of ready tickets
            ST_SUM:
            begin
                rd_en         = issue_more;
                rd_addr       = issue_reg[AW-1:0];
                issue_next    = issue_more ? issue_reg + 1'b1 : issue_reg;
                pend_next     = issue_more;
                pend_idx_next = issue_reg[AW-1:0];
                if (pend_reg && rd_ready)
                begin
                    total_next = total_reg + CW'(rd_count);
                end
                if (!issue_more && !pend_reg)
                begin
                    if (total_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    drawn_next = div_rem;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    low_next   = '0;
                    state_next = ST_WALK;
                end
            end

            // second walk: first ready slot whose range [low, low+count) holds the draw
            ST_WALK:
            begin
                rd_en         = issue_more;
                rd_addr       = issue_reg[AW-1:0];
                issue_next    = issue_more ? issue_reg + 1'b1 : issue_reg;
                pend_next     = issue_more;
                pend_idx_next = issue_reg[AW-1:0];
                if (pend_reg && rd_ready)
                begin
                    if (CW'(drawn_reg) < hi_bound)
                    begin
                        found_next   = 1'b1;
                        win_idx_next = pend_idx_reg;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        low_next = hi_bound;
                    end
                end
                if (!issue_more && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next = 1'b1;
                    o_slot_next  = found_reg ? idx9[lsch_pkg::SLOT_W-1:0] : '0;
                    o_win_next   = found_reg;
                    o_drawn_next = drawn_reg;
                    o_moved_next = moved_ext[lsch_pkg::VALUE_W-1:0];
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= lsch_pkg::MODE_SET;
            src_reg      <= '0;
            dst_reg      <= '0;
            value_reg    <= '0;
            rdy_reg      <= 1'b0;
            rnd_reg      <= '0;
            moved_reg    <= '0;
            total_reg    <= '0;
            low_reg      <= '0;
            drawn_reg    <= '0;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            win_idx_reg  <= '0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
            o_slot_reg   <= '0;
            o_win_reg    <= 1'b0;
            o_drawn_reg  <= '0;
            o_moved_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            value_reg    <= value_next;
            rdy_reg      <= rdy_next;
            rnd_reg      <= rnd_next;
            moved_reg    <= moved_next;
            total_reg    <= total_next;
            low_reg      <= low_next;
            drawn_reg    <= drawn_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            win_idx_reg  <= win_idx_next;
            found_reg    <= found_next;
            out_vld_reg  <= out_vld_next;
            o_slot_reg   <= o_slot_next;
            o_win_reg    <= o_win_next;
            o_drawn_reg  <= o_drawn_next;
            o_moved_reg  <= o_moved_next;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_vld_reg;
    assign winner_slot   = o_slot_reg;
    assign winner_valid  = o_win_reg;
    assign lucky_ticket  = o_drawn_reg;
    assign moved_tickets = o_moved_reg;

endmodule

`default_nettype wire

>>> sv/lsch_table.sv
// Slot table: one synchronous RAM of {ready, ticket count} with per-entry valid flags.
// An entry never written reads as zero. No package dependencies.
`default_nettype none

module lsch_table #(
    parameter int SLOT_COUNT  = 16,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
    output logic                               rd_ready,
    output logic [TICKET_BITS-1:0]             rd_count,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
    input  wire logic                          wr_ready,
    input  wire logic [TICKET_BITS-1:0]        wr_count
);

    logic [TICKET_BITS:0]   ram [SLOT_COUNT];
    logic [TICKET_BITS:0]   rd_data_reg;
    logic                   rd_vld_reg;
    logic [SLOT_COUNT-1:0]  vld_reg;

    // RAM body: no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= {wr_ready, wr_count};
        end
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    // Valid flags stand in for clearing the RAM at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_ready = rd_vld_reg & rd_data_reg[TICKET_BITS];
    assign rd_count = rd_vld_reg ? rd_data_reg[TICKET_BITS-1:0] : '0;

endmodule

`default_nettype wire

>>> sv/lsch_mod_unit.sv
// Iterative remainder unit: random word mod ticket total, one dividend bit a cycle.
// Depends on lsch_pkg for the random word width.
`default_nettype none

module lsch_mod_unit #(
    parameter int DIVISOR_W = 21
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lsch_pkg::RAND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]        divisor,
    output logic                             done,
    output logic [lsch_pkg::RAND_W-1:0]      remainder
);

    localparam int RW = lsch_pkg::RAND_W;
    localparam int TW = (DIVISOR_W > RW + 1) ? DIVISOR_W : RW + 1;
    localparam int CNT_W = $clog2(RW);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  step_reg,  step_next;
    logic [RW-1:0]     rem_reg,   rem_next;
    logic [RW-1:0]     dvd_reg,   dvd_next;

    logic [TW-1:0]     trial;
    logic [TW-1:0]     div_ext;
    logic [TW-1:0]     diff;

    always_comb
    begin
        trial   = TW'({rem_reg, dvd_reg[RW-1]});
        div_ext = TW'(divisor);
        diff    = trial - div_ext;

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = CNT_W'(RW - 1);
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            // partial remainder never exceeds the dividend, so RW bits hold it
            rem_next = (trial >= div_ext) ? diff[RW-1:0] : trial[RW-1:0];
            dvd_next = {dvd_reg[RW-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
